>>> rtl/wbps_pkg.sv
// Shared types, register indexes and helper function of the byte pattern scanner.
package wbps_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int ADDR_W      = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_FIRST_HALF  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_SECOND_HALF = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_BASE          = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RESULT_OFFSET       = 3'd4;

    localparam logic [7:0] WILDCARD_BYTE = 8'h00;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] match_address;
    } out_item_t;

    typedef struct packed {
        logic [63:0]              pattern_first_half;
        logic [63:0]              pattern_second_half;
        logic [4:0]               pattern_length;
        logic [ADDR_W-1:0]        image_base;
        logic signed [ADDR_W-1:0] result_offset;
    } cfg_t;

    typedef struct packed {
        logic              last_byte;
        logic [ADDR_W-1:0] position;
    } scan_item_t;

    function automatic logic [7:0] pattern_byte(input logic [63:0] lo, input logic [63:0] hi,
                                                input logic [3:0] idx);
        logic [63:0] half;
        half = idx[3] ? hi : lo;
        return half[{idx[2:0], 3'b000} +: 8];
    endfunction

endpackage

>>> rtl/wildcard_byte_pattern_scanner.sv
// Top level of the wildcard byte pattern scanner: stages, match flag and result register.
//
// The s_ channel carries one byte of a memory image per transaction, with
// last_byte set on the final byte. Each accepted byte shifts into a window
// that is compared in parallel with the configured pattern, where a zero
// pattern byte matches anything. The first matching window of an image
// yields one m_ transaction with found set and the address image_base plus
// start position plus result_offset. If the image ends without a match, one
// transaction with found clear and a zero address is sent at the last byte.
// The cfg_wr_ port writes a register at each clock edge with the enable
// high; write only while no transaction is in flight.
// An accepted byte is registered in the input stage and its result then in the result
// register; one byte is accepted every cycle while m_ready stays high. When the
// receiver stalls, the input stage holds one more byte and then s_ready
// drops until the result register is taken. Synchronous reset clears the
// configuration to its defaults and restarts the scan of a new image.
module wildcard_byte_pattern_scanner
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_item,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_item
);

    cfg_t                           cfg;
    logic                           st_valid;
    logic [MAX_PATTERN_BYTES*8-1:0] window;
    scan_item_t                     scan;
    logic                           hit;
    logic [ADDR_W-1:0]              match_address;
    logic                           advance;
    logic                           eval;
    logic                           report;
    logic                           m_valid_reg;
    logic                           m_valid_next;
    out_item_t                      m_item_reg;
    out_item_t                      m_item_next;
    logic                           reported_reg;
    logic                           reported_next;

    wbps_cfg_regs u_cfg_regs (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    wbps_window #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .advance  (advance),
        .st_valid (st_valid),
        .window   (window),
        .scan     (scan)
    );

    wbps_matcher #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_matcher (
        .cfg           (cfg),
        .window        (window),
        .scan          (scan),
        .hit           (hit),
        .match_address (match_address)
    );

    assign advance = !m_valid_reg || m_ready;
    assign eval    = st_valid && advance;
    assign report  = !reported_reg && (hit || scan.last_byte);

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_item_next   = m_item_reg;
        reported_next = reported_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (eval) begin
            if (report) begin
                m_valid_next              = 1'b1;
                m_item_next.found         = hit;
                m_item_next.match_address = hit ? match_address : '0;
            end
            reported_next = scan.last_byte ? 1'b0 : (reported_reg || hit);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            reported_reg <= 1'b0;
        end else begin
            m_valid_reg  <= m_valid_next;
            reported_reg <= reported_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

>>> rtl/wbps_cfg_regs.sv
// Configuration register file of the byte pattern scanner.
module wbps_cfg_regs
    import wbps_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_PATTERN_FIRST_HALF: begin
                    cfg_next.pattern_first_half = cfg_wr_data;
                end
                REG_PATTERN_SECOND_HALF: begin
                    cfg_next.pattern_second_half = cfg_wr_data;
                end
                REG_PATTERN_LENGTH: begin
                    cfg_next.pattern_length = cfg_wr_data[4:0];
                end
                REG_IMAGE_BASE: begin
                    cfg_next.image_base = cfg_wr_data[ADDR_W-1:0];
                end
                REG_RESULT_OFFSET: begin
                    cfg_next.result_offset = signed'(cfg_wr_data[ADDR_W-1:0]);
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pattern_first_half  <= '0;
            cfg_reg.pattern_second_half <= '0;
            cfg_reg.pattern_length      <= 5'd1;
            cfg_reg.image_base          <= '0;
            cfg_reg.result_offset       <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/wbps_window.sv
// Input stage: sliding byte window and byte position of the current image.
module wbps_window
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  in_item_t                       s_item,
    input  logic                           advance,
    output logic                           st_valid,
    output logic [MAX_PATTERN_BYTES*8-1:0] window,
    output scan_item_t                     scan
);

    logic                           valid_reg;
    logic                           valid_next;
    logic                           restart_reg;
    logic                           restart_next;
    logic [MAX_PATTERN_BYTES*8-1:0] win_reg;
    logic [MAX_PATTERN_BYTES*8-1:0] win_next;
    logic [ADDR_W-1:0]              pos_reg;
    logic [ADDR_W-1:0]              pos_next;
    logic                           last_reg;
    logic                           last_next;
    logic                           accept;

    assign s_ready = !valid_reg || advance;
    assign accept  = s_valid && s_ready;

    always_comb begin
        valid_next   = valid_reg;
        restart_next = restart_reg;
        win_next     = win_reg;
        pos_next     = pos_reg;
        last_next    = last_reg;
        if (accept) begin
            valid_next = 1'b1;
            for (int j = 0; j < MAX_PATTERN_BYTES - 1; j++) begin
                win_next[j*8 +: 8] = win_reg[(j+1)*8 +: 8];
            end
            win_next[(MAX_PATTERN_BYTES-1)*8 +: 8] = s_item.data_byte;
            pos_next     = (restart_reg ? '0 : pos_reg) + 1'b1;
            last_next    = s_item.last_byte;
            restart_next = s_item.last_byte;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            restart_reg <= 1'b0;
            pos_reg     <= '0;
        end else begin
            valid_reg   <= valid_next;
            restart_reg <= restart_next;
            pos_reg     <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg  <= win_next;
        last_reg <= last_next;
    end

    assign st_valid       = valid_reg;
    assign window         = win_reg;
    assign scan.last_byte = last_reg;
    assign scan.position  = pos_reg;

endmodule

>>> rtl/wbps_matcher.sv
// Parallel wildcard compare of the window against the pattern, and match address.
module wbps_matcher
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = 16
) (
    input  cfg_t                           cfg,
    input  logic [MAX_PATTERN_BYTES*8-1:0] window,
    input  scan_item_t                     scan,
    output logic                           hit,
    output logic [ADDR_W-1:0]              match_address
);

    localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

    logic [LEN_W-1:0] len_act;
    logic [7:0]       win_bytes [MAX_PATTERN_BYTES];
    logic [LEN_W-1:0] idx       [MAX_PATTERN_BYTES];
    logic [7:0]       pat       [MAX_PATTERN_BYTES];
    logic             all_match;
    logic             full;

    always_comb begin
        if (cfg.pattern_length == 5'd0) begin
            len_act = LEN_W'(1);
        end else if (cfg.pattern_length > 5'(MAX_PATTERN_BYTES)) begin
            len_act = LEN_W'(MAX_PATTERN_BYTES);
        end else begin
            len_act = cfg.pattern_length[LEN_W-1:0];
        end
    end

    always_comb begin
        all_match = 1'b1;
        for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
            win_bytes[i] = window[i*8 +: 8];
            idx[i]       = LEN_W'(MAX_PATTERN_BYTES) - len_act + LEN_W'(i);
            pat[i]       = pattern_byte(cfg.pattern_first_half, cfg.pattern_second_half, 4'(i));
        end
        for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
            if (LEN_W'(i) < len_act) begin
                if (pat[i] != WILDCARD_BYTE && pat[i] != win_bytes[idx[i][IDX_W-1:0]]) begin
                    all_match = 1'b0;
                end
            end
        end
    end

    // A position of zero here means the byte count wrapped past the top of the range.
    assign full = (scan.position == '0) || (scan.position >= ADDR_W'(len_act));
    assign hit  = full && all_match;

    assign match_address = cfg.image_base + (scan.position - ADDR_W'(len_act))
                         + unsigned'(cfg.result_offset);

endmodule
